### hdl/u2da_pkg.sv
package u2da_pkg;

   // Width of one BCD digit.
   localparam int unsigned DIGIT_W = 4;

   // Result field widths.
   localparam int unsigned ASCII_W = 6;
   localparam int unsigned COUNT_W = 5;

   // Upper bits of an ASCII decimal digit; the low nibble carries the digit itself.
   localparam logic [ASCII_W-DIGIT_W-1:0] ASCII_DIGIT_HI = 2'b11;

   // Smallest digit value that needs the add-3 correction before a shift.
   localparam logic [DIGIT_W-1:0] DIGIT_ADJUST_MIN = 4'd5;
   localparam logic [DIGIT_W-1:0] DIGIT_ADJUST_ADD = 4'd3;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX        = 4'd9;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

endpackage

### hdl/u2da_dabble_step.sv
// One shift-add-3 step of the binary to BCD conversion: each digit of five or
// more gets three added, then the whole BCD word shifts left by one and takes
// in the next binary bit. The bit pushed out of the top digit is returned so
// that the caller can notice a value too long for the digit register.
module u2da_dabble_step #(
   parameter int unsigned DIGITS = 20
) (
   input  logic [DIGITS*u2da_pkg::DIGIT_W-1:0] bcd,
   input  logic                                bit_in,
   output logic [DIGITS*u2da_pkg::DIGIT_W-1:0] bcd_next,
   output logic                                carry_out
);

   localparam int unsigned BCD_W = DIGITS * u2da_pkg::DIGIT_W;

   logic [BCD_W-1:0] adjusted;

   // Correct every digit independently.
   always_comb begin
      adjusted = bcd;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd[i*u2da_pkg::DIGIT_W +: u2da_pkg::DIGIT_W] >= u2da_pkg::DIGIT_ADJUST_MIN) begin
            adjusted[i*u2da_pkg::DIGIT_W +: u2da_pkg::DIGIT_W] =
               bcd[i*u2da_pkg::DIGIT_W +: u2da_pkg::DIGIT_W] + u2da_pkg::DIGIT_ADJUST_ADD;
         end
      end
   end

   // Shift by one and bring in the next binary bit.
   assign {carry_out, bcd_next} = {adjusted, bit_in};

endmodule

### hdl/unsigned_to_decimal_ascii_core.sv
// Unsigned binary to decimal ASCII text.
//
// A word on the req_ channel carries one unsigned value; its low VALUE_BITS
// bits are converted. The rsp_ channel then returns the decimal text one
// character per word, most significant digit first, with no leading zeros
// (zero gives a single '0'). Each word also carries the total digit count,
// and rsp_is_last marks the least significant character. When the text is
// longer than MAX_DIGITS, only the MAX_DIGITS low digits are sent, zeros too.
//
// Timing: one shared shift-add-3 unit converts the value bit by bit, a
// leading-zero scan then drops leading zeros one digit per cycle, and the
// characters follow one per cycle while rsp_stall is low. A new value waits
// for the conversion loop and the digit shift register: req_stall is high
// from acceptance until the last character has been loaded into the output
// register, so the next value is taken while that character still waits.
// A high rsp_stall holds the output word and pauses the character stream.
// Synchronous reset returns the sequencer to idle and drops rsp_valid.
module unsigned_to_decimal_ascii_core #(
   parameter int unsigned VALUE_BITS = 64,
   parameter int unsigned MAX_DIGITS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [63:0]                       req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [u2da_pkg::ASCII_W-1:0]      rsp_ascii_char,
   output logic [u2da_pkg::COUNT_W-1:0]      rsp_digit_count,
   output logic                              rsp_is_last
);

   localparam int unsigned BCD_W = MAX_DIGITS * u2da_pkg::DIGIT_W;
   localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

   u2da_pkg::state_type state_ff, state_in;

   logic [VALUE_BITS-1:0]        bin_ff, bin_in;
   logic [BCD_W-1:0]             bcd_ff, bcd_in;
   logic                         ovf_ff, ovf_in;
   logic [CNT_W-1:0]             bit_cnt_ff, bit_cnt_in;
   logic [u2da_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [u2da_pkg::COUNT_W-1:0] remain_ff, remain_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [u2da_pkg::ASCII_W-1:0] rsp_char_ff, rsp_char_in;
   logic [u2da_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [BCD_W-1:0]             step_bcd;
   logic                         step_carry;
   logic [u2da_pkg::DIGIT_W-1:0] top_digit;
   logic [BCD_W-1:0]             bcd_shifted;
   logic                         req_accept;
   logic                         slot_free;

   // Shared shift-add-3 unit.
   u2da_dabble_step #(
      .DIGITS(MAX_DIGITS)
   ) u_step (
      .bcd      (bcd_ff),
      .bit_in   (bin_ff[VALUE_BITS-1]),
      .bcd_next (step_bcd),
      .carry_out(step_carry)
   );

   assign top_digit   = bcd_ff[BCD_W-1 -: u2da_pkg::DIGIT_W];
   assign bcd_shifted = {bcd_ff[BCD_W-u2da_pkg::DIGIT_W-1:0], {u2da_pkg::DIGIT_W{1'b0}}};

   assign req_stall  = (state_ff != u2da_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   // Sequencer: load, convert, drop leading zeros, emit characters.
   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      ovf_in       = ovf_ff;
      bit_cnt_in   = bit_cnt_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         u2da_pkg::ST_IDLE: begin
            if (req_accept) begin
               bin_in     = req_value[VALUE_BITS-1:0];
               bcd_in     = '0;
               ovf_in     = 1'b0;
               bit_cnt_in = CNT_W'(VALUE_BITS);
               state_in   = u2da_pkg::ST_CONV;
            end
         end
         u2da_pkg::ST_CONV: begin
            bcd_in     = step_bcd;
            ovf_in     = ovf_ff || step_carry;
            bin_in     = {bin_ff[VALUE_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == CNT_W'(1)) begin
               count_in = u2da_pkg::COUNT_W'(MAX_DIGITS);
               state_in = u2da_pkg::ST_SCAN;
            end
         end
         u2da_pkg::ST_SCAN: begin
            // A too-long text keeps its leading zeros; otherwise drop them.
            if (ovf_ff || (top_digit != '0) || (count_ff == u2da_pkg::COUNT_W'(1))) begin
               remain_in = count_ff;
               state_in  = u2da_pkg::ST_EMIT;
            end else begin
               bcd_in   = bcd_shifted;
               count_in = count_ff - 1'b1;
            end
         end
         u2da_pkg::ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = {u2da_pkg::ASCII_DIGIT_HI, top_digit};
               rsp_count_in = count_ff;
               rsp_last_in  = (remain_ff == u2da_pkg::COUNT_W'(1));
               bcd_in       = bcd_shifted;
               remain_in    = remain_ff - 1'b1;
               if (remain_ff == u2da_pkg::COUNT_W'(1)) begin
                  state_in = u2da_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = u2da_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= u2da_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
      ovf_ff       <= ovf_in;
      bit_cnt_ff   <= bit_cnt_in;
      count_ff     <= count_in;
      remain_ff    <= remain_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ascii_char  = rsp_char_ff;
   assign rsp_digit_count = rsp_count_ff;
   assign rsp_is_last     = rsp_last_ff;

   // An accepted value always starts the conversion loop.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == u2da_pkg::ST_CONV))
      else $error("accepted word did not start conversion");

   // Every character sent is a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_ascii_char[5:4] == u2da_pkg::ASCII_DIGIT_HI) &&
                     (rsp_ascii_char[3:0] <= u2da_pkg::DIGIT_MAX)))
      else $error("character out of decimal range");

   // The digit count stays within one and the digit register size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_digit_count != '0) &&
                     (rsp_digit_count <= u2da_pkg::COUNT_W'(MAX_DIGITS))))
      else $error("digit count out of range");

   // The first character of a text is never a zero unless it is the only one
   // or the text was cut to the digit register size.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == u2da_pkg::ST_SCAN) && (state_in == u2da_pkg::ST_EMIT) |->
         (ovf_ff || (top_digit != '0) || (count_ff == u2da_pkg::COUNT_W'(1))))
      else $error("leading zero left in text");

endmodule
